// ----- src/lightmap_style_combine_pack_assert.svh -----
// Assertion macros for the lightmap style combine block
`ifndef LIGHTMAP_STYLE_COMBINE_PACK_ASSERT_SVH
`define LIGHTMAP_STYLE_COMBINE_PACK_ASSERT_SVH

// prop must hold at every clock edge outside reset
`define LSCP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lscp assertion failed");

// cons must hold in the cycle after ante
`define LSCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lscp assertion failed");

`endif

// ----- src/lscp_pkg.sv -----
package lscp_pkg;

  localparam int MAX_LAYERS = 4;
  localparam int LAYER_W    = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int CNT_W      = ($clog2(MAX_LAYERS + 1) > 3) ? $clog2(MAX_LAYERS + 1) : 3;
  // one layer adds less than 2^25 in magnitude
  localparam int SUM_W      = 26 + $clog2(MAX_LAYERS);
  localparam int CH_W       = SUM_W - 9;
  localparam int NUM_W      = CH_W + 8;

  localparam int NUM_SCALE   = 4;
  localparam int SCALE_IDX_W = 2;
  localparam int SAMPLE_W    = 8;
  localparam int DYN_W       = 24;
  localparam int FACTOR_W    = 16;
  localparam int SCALE_W     = 48;
  localparam int BYTE_W      = 8;
  localparam int QUO_W       = 8;
  localparam int NUM_CH      = 3;
  localparam int NUM_MAPS_W  = 3;

  localparam int S_TDATA_W = NUM_CH * (SAMPLE_W + DYN_W);
  localparam int M_TDATA_W = 4 * BYTE_W;
  localparam int CFG_IDX_W = 3;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 48'h0100_0100_0100;
  localparam logic [BYTE_W-1:0]  FULL_BYTE   = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_MAPS    = 3'd0,
    CFG_HAS_SAMPLES = 3'd1,
    CFG_BGRA_ORDER  = 3'd2,
    CFG_SCALE_MAP0  = 3'd3,
    CFG_SCALE_MAP1  = 3'd4,
    CFG_SCALE_MAP2  = 3'd5,
    CFG_SCALE_MAP3  = 3'd6
  } cfg_idx_e;

endpackage

// ----- src/lightmap_style_combine_pack.sv -----
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  one layer sample and dynamic light
// m_axis    out  m_axis_tvalid/m_axis_tready  packed texel bytes, alpha on top
// cfg       in   cfg_we_i                     register index and data
//
// A layer that is not the last of its texel is accepted, then makes three
// channel passes through the one 8x16 multiply-add.
// The last layer adds a scan state and an output state; when a channel exceeds
// 255, the shared restoring divider works through each channel in turn first.
// Full bright texels go straight to output. Reset clears the running sums at once.
// A result waits in the output register; the next item is taken meanwhile.
module lightmap_style_combine_pack import lscp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // sample_red, sample_green, sample_blue, dyn_red, dyn_green, dyn_blue
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // out_first, out_second, out_third, out_alpha
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SCALE_W-1:0]   cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_SCAN,
    ST_DIV,
    ST_OUT
  } state_e;

  logic [NUM_MAPS_W-1:0] num_maps_q;
  logic                  has_samples_q;
  logic                  bgra_q;
  logic [SCALE_W-1:0]    scale_q [NUM_SCALE];

  state_e                    state_q;
  logic [1:0]                chan_q;
  logic [2:0]                step_q;
  logic [LAYER_W-1:0]        layer_q;
  logic signed [SUM_W-1:0]   sum_q [NUM_CH];
  logic [SAMPLE_W-1:0]       smp_q [NUM_CH];
  logic signed [DYN_W-1:0]   dyn_q [NUM_CH];
  logic [CH_W-1:0]           ch_q  [NUM_CH];
  logic [CH_W-1:0]           mx_q;
  logic [NUM_W-1:0]          rem_q;
  logic [NUM_W-1:0]          den_q;
  logic [QUO_W-1:0]          quo_q;
  logic [BYTE_W-1:0]         res_q [NUM_CH];
  logic                      mvalid_q;
  logic [M_TDATA_W-1:0]      mdata_q;

  logic [SCALE_IDX_W-1:0]    scale_idx;
  logic [FACTOR_W-1:0]       factor;
  logic [SAMPLE_W+FACTOR_W-1:0] prod;
  logic signed [SUM_W-1:0]   mac_sum;
  logic [CNT_W-1:0]          num_ext;
  logic [CNT_W-1:0]          eff_layers;
  logic [CNT_W-1:0]          cnt_next;
  logic                      last_layer;
  logic [CH_W-1:0]           flr [NUM_CH];
  logic [CH_W-1:0]           mx;
  logic                      div_ge;
  logic [1:0]                chan_nx;
  logic [QUO_W-1:0]          quo_nx;

  function automatic logic [NUM_W-1:0] times255(input logic [CH_W-1:0] v);
    return {v, 8'd0} - {8'd0, v};
  endfunction

  always_comb begin
    if (32'(layer_q) > NUM_SCALE - 1) begin
      scale_idx = SCALE_IDX_W'(NUM_SCALE - 1);
    end else begin
      scale_idx = SCALE_IDX_W'(layer_q);
    end
    case (chan_q)
      2'd0:    factor = scale_q[scale_idx][47:32];
      2'd1:    factor = scale_q[scale_idx][31:16];
      default: factor = scale_q[scale_idx][15:0];
    endcase
    prod    = smp_q[chan_q] * factor;
    mac_sum = sum_q[chan_q] + SUM_W'($signed({1'b0, prod})) + SUM_W'(dyn_q[chan_q]);

    num_ext = CNT_W'(num_maps_q);
    if (num_ext == '0) begin
      eff_layers = CNT_W'(1);
    end else if (32'(num_ext) > MAX_LAYERS) begin
      eff_layers = CNT_W'(MAX_LAYERS);
    end else begin
      eff_layers = num_ext;
    end
    cnt_next   = CNT_W'(layer_q) + CNT_W'(1);
    last_layer = (cnt_next >= eff_layers);

    mx = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      flr[c] = sum_q[c][SUM_W-1] ? '0 : sum_q[c][SUM_W-2:8];
      if (flr[c] > mx) begin
        mx = flr[c];
      end
    end

    div_ge  = (rem_q >= den_q);
    quo_nx  = {quo_q[QUO_W-2:0], div_ge};
    chan_nx = chan_q + 2'd1;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = mdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_maps_q    <= NUM_MAPS_W'(1);
      has_samples_q <= 1'b1;
      bgra_q        <= 1'b0;
      for (int i = 0; i < NUM_SCALE; i++) begin
        scale_q[i] <= SCALE_RESET;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NUM_MAPS:    num_maps_q    <= cfg_data_i[NUM_MAPS_W-1:0];
        CFG_HAS_SAMPLES: has_samples_q <= cfg_data_i[0];
        CFG_BGRA_ORDER:  bgra_q        <= cfg_data_i[0];
        CFG_SCALE_MAP0:  scale_q[0]    <= cfg_data_i;
        CFG_SCALE_MAP1:  scale_q[1]    <= cfg_data_i;
        CFG_SCALE_MAP2:  scale_q[2]    <= cfg_data_i;
        CFG_SCALE_MAP3:  scale_q[3]    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      chan_q   <= '0;
      step_q   <= '0;
      layer_q  <= '0;
      mx_q     <= '0;
      rem_q    <= '0;
      den_q    <= '0;
      quo_q    <= '0;
      mvalid_q <= 1'b0;
      mdata_q  <= '0;
      for (int c = 0; c < NUM_CH; c++) begin
        sum_q[c] <= '0;
        smp_q[c] <= '0;
        dyn_q[c] <= '0;
        ch_q[c]  <= '0;
        res_q[c] <= '0;
      end
    end else begin
      if (mvalid_q && m_axis_tready && (state_q != ST_OUT)) begin
        mvalid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            for (int c = 0; c < NUM_CH; c++) begin
              smp_q[c] <= s_axis_tdata[c*SAMPLE_W +: SAMPLE_W];
              dyn_q[c] <= s_axis_tdata[NUM_CH*SAMPLE_W + c*DYN_W +: DYN_W];
            end
            chan_q <= '0;
            if (!has_samples_q) begin
              layer_q <= '0;
              for (int c = 0; c < NUM_CH; c++) begin
                sum_q[c] <= '0;
                res_q[c] <= FULL_BYTE;
              end
              state_q <= ST_OUT;
            end else begin
              state_q <= ST_MAC;
            end
          end
        end
        ST_MAC: begin
          sum_q[chan_q] <= mac_sum;
          if (chan_q == 2'd2) begin
            if (last_layer) begin
              state_q <= ST_SCAN;
            end else begin
              layer_q <= layer_q + LAYER_W'(1);
              state_q <= ST_IDLE;
            end
          end else begin
            chan_q <= chan_nx;
          end
        end
        ST_SCAN: begin
          layer_q <= '0;
          mx_q    <= mx;
          for (int c = 0; c < NUM_CH; c++) begin
            sum_q[c] <= '0;
            ch_q[c]  <= flr[c];
            res_q[c] <= flr[c][BYTE_W-1:0];
          end
          if (mx > CH_W'(255)) begin
            chan_q  <= '0;
            step_q  <= '0;
            rem_q   <= times255(flr[0]);
            den_q   <= NUM_W'(mx) << 7;
            state_q <= ST_DIV;
          end else begin
            state_q <= ST_OUT;
          end
        end
        ST_DIV: begin
          quo_q  <= quo_nx;
          step_q <= step_q + 3'd1;
          if (step_q == 3'd7) begin
            res_q[chan_q] <= quo_nx;
            if (chan_q == 2'd2) begin
              state_q <= ST_OUT;
            end else begin
              chan_q <= chan_nx;
              rem_q  <= times255(ch_q[chan_nx]);
              den_q  <= NUM_W'(mx_q) << 7;
            end
          end else begin
            if (div_ge) begin
              rem_q <= rem_q - den_q;
            end
            den_q <= den_q >> 1;
          end
        end
        ST_OUT: begin
          if (!mvalid_q || m_axis_tready) begin
            mvalid_q <= 1'b1;
            mdata_q  <= {FULL_BYTE,
                         bgra_q ? res_q[0] : res_q[2],
                         res_q[1],
                         bgra_q ? res_q[2] : res_q[0]};
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- src/lscp_checker.sv -----
`include "lightmap_style_combine_pack_assert.svh"

module lscp_checker import lscp_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  // hold a stalled result
  `LSCP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  `LSCP_ASSERT(a_alpha_full, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tdata[M_TDATA_W-1 -: BYTE_W] == FULL_BYTE))

  // busy after every input transfer
  `LSCP_ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  `LSCP_ASSERT_NEXT(a_no_instant_out, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid))

endmodule

bind lightmap_style_combine_pack lscp_checker u_lscp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- verif/lightmap_style_combine_pack_checker.sv -----
module lightmap_style_combine_pack_checker import lscp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  // sample_red, sample_green, sample_blue, dyn_red, dyn_green, dyn_blue
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // out_first, out_second, out_third, out_alpha
  input  logic [M_TDATA_W-1:0] m_axis_tdata,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SCALE_W-1:0]   cfg_data_i,
  output int                   fail_cnt_o,
  output int                   due_o
);

  typedef struct packed {
    logic [BYTE_W-1:0] alpha;
    logic [BYTE_W-1:0] third;
    logic [BYTE_W-1:0] second;
    logic [BYTE_W-1:0] first;
  } texel_t;

  texel_t texel_q[$];
  int     mismatches = 0;
  int     waiting    = 0;

  logic [NUM_MAPS_W-1:0] num_maps_r  = 1;
  logic                  has_samples_r = 1'b1;
  logic                  bgra_r      = 1'b0;
  logic [SCALE_W-1:0]    scale_r[NUM_SCALE];

  logic [CNT_W-1:0]        layers_taken = '0;
  logic signed [SUM_W-1:0] chan_sum[NUM_CH];

  assign fail_cnt_o = mismatches;
  assign due_o      = waiting;

  function automatic void clear_texel();
    layers_taken = '0;
    for (int c = 0; c < NUM_CH; c++) chan_sum[c] = '0;
  endfunction

  function automatic bit fold_layer(input logic [S_TDATA_W-1:0] d, output texel_t t);
    logic [SAMPLE_W-1:0]    smp;
    logic signed [DYN_W-1:0] dyn;
    logic [FACTOR_W-1:0]    fac;
    logic [SCALE_W-1:0]     sc;
    logic [CH_W-1:0]        lvl[NUM_CH];
    logic [CH_W-1:0]        peak;
    logic [CH_W+7:0]        prod;
    int unsigned            want;
    t = '1;
    if (!has_samples_r) begin
      clear_texel();
      return 1'b1;
    end
    sc = scale_r[(layers_taken > NUM_SCALE - 1) ? NUM_SCALE - 1 : layers_taken];
    for (int c = 0; c < NUM_CH; c++) begin
      smp = d[c*SAMPLE_W +: SAMPLE_W];
      dyn = d[NUM_CH*SAMPLE_W + c*DYN_W +: DYN_W];
      fac = sc[(NUM_CH-1-c)*FACTOR_W +: FACTOR_W];
      chan_sum[c] = SUM_W'(longint'(chan_sum[c]) + longint'(smp) * longint'(fac)
                           + longint'(dyn));
    end
    layers_taken = layers_taken + 1'b1;
    want = (num_maps_r == 0) ? 1 : (num_maps_r > MAX_LAYERS) ? MAX_LAYERS : num_maps_r;
    if (layers_taken < want) return 1'b0;
    peak = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      lvl[c] = (chan_sum[c] < 0) ? '0 : CH_W'(chan_sum[c] >>> 8);
      if (lvl[c] > peak) peak = lvl[c];
    end
    if (peak > 255) begin
      for (int c = 0; c < NUM_CH; c++) begin
        prod   = lvl[c] * 255;
        lvl[c] = CH_W'(prod / peak);
      end
    end
    clear_texel();
    t.first  = bgra_r ? lvl[2][7:0] : lvl[0][7:0];
    t.second = lvl[1][7:0];
    t.third  = bgra_r ? lvl[0][7:0] : lvl[2][7:0];
    t.alpha  = FULL_BYTE;
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    texel_t seen;
    texel_t want_t;
    texel_t made;
    if (!rst_ni) begin
      num_maps_r    = 1;
      has_samples_r = 1'b1;
      bgra_r        = 1'b0;
      for (int i = 0; i < NUM_SCALE; i++) scale_r[i] = SCALE_RESET;
      clear_texel();
      texel_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen = m_axis_tdata;
        if (texel_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected texel %02h %02h %02h %02h", seen.first, seen.second,
                     seen.third, seen.alpha);
          mismatches++;
        end else begin
          want_t = texel_q.pop_front();
          if (seen.first != want_t.first || seen.second != want_t.second ||
              seen.third != want_t.third || seen.alpha != want_t.alpha) begin
            if (mismatches < 10)
              $display("texel mismatch: expected %02h %02h %02h %02h, got %02h %02h %02h %02h",
                       want_t.first, want_t.second, want_t.third, want_t.alpha,
                       seen.first, seen.second, seen.third, seen.alpha);
            mismatches++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_NUM_MAPS:    num_maps_r    = cfg_data_i[NUM_MAPS_W-1:0];
          CFG_HAS_SAMPLES: has_samples_r = cfg_data_i[0];
          CFG_BGRA_ORDER:  bgra_r        = cfg_data_i[0];
          CFG_SCALE_MAP0:  scale_r[0]    = cfg_data_i;
          CFG_SCALE_MAP1:  scale_r[1]    = cfg_data_i;
          CFG_SCALE_MAP2:  scale_r[2]    = cfg_data_i;
          CFG_SCALE_MAP3:  scale_r[3]    = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (fold_layer(s_axis_tdata, made)) texel_q.push_back(made);
      end
    end
    waiting = texel_q.size();
  end

endmodule

// ----- verif/lightmap_style_combine_pack_tb.sv -----
module lightmap_style_combine_pack_tb;
  import lscp_pkg::*;

  localparam int SETTLE      = 40;
  localparam int QUIET_LIMIT = 4000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 60;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [SCALE_W-1:0]   cfg_data_i    = '0;

  int fails;
  int due;
  int stall_odds = 0;
  int send_odds  = 0;
  int hold_left  = 0;
  int quiet      = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  lightmap_style_combine_pack u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  lightmap_style_combine_pack_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .fail_cnt_o    (fails),
    .due_o         (due)
  );

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
      end else if (stall_odds != 0 && $urandom_range(0, 99) < stall_odds) begin
        m_axis_tready <= 1'b0;
        hold_left = $urandom_range(0, 11);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("lightmap_style_combine_pack_tb failed");
        $finish;
      end
    end
  end

  task automatic send_layer(input logic [7:0] r, g, b, input logic [23:0] dr, dg, db);
    int gap;
    gap = (send_odds != 0 && $urandom_range(0, 99) < send_odds) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {db, dg, dr, b, g, r};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // hold off until every texel is out, then let the block settle
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (due != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [SCALE_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic setup(input int nm, input bit has, input bit bgra,
                       input logic [SCALE_W-1:0] s0, s1, s2, s3);
    write_reg(CFG_NUM_MAPS, SCALE_W'(nm));
    write_reg(CFG_HAS_SAMPLES, SCALE_W'(has));
    write_reg(CFG_BGRA_ORDER, SCALE_W'(bgra));
    write_reg(CFG_SCALE_MAP0, s0);
    write_reg(CFG_SCALE_MAP1, s1);
    write_reg(CFG_SCALE_MAP2, s2);
    write_reg(CFG_SCALE_MAP3, s3);
  endtask

  function automatic logic [FACTOR_W-1:0] pick_factor();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 16'h0100;
      3: return FACTOR_W'($urandom_range(0, 16'h0200));
      default: return FACTOR_W'($urandom);
    endcase
  endfunction

  function automatic logic [SCALE_W-1:0] pick_scale();
    return {pick_factor(), pick_factor(), pick_factor()};
  endfunction

  function automatic logic [7:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [23:0] pick_dyn();
    case ($urandom_range(0, 3))
      0: return 24'($urandom);
      1: return 24'($urandom_range(0, 4095)) - 24'd2048;
      default: return 24'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random_layer();
    send_layer(pick_sample(), pick_sample(), pick_sample(), pick_dyn(), pick_dyn(), pick_dyn());
  endtask

  function automatic int pick_odds();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 5;
      2: return 15;
      default: return 30;
    endcase
  endfunction

  initial begin
    int nm;
    int pause_at;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: one layer, unit scales, red first
    send_layer(8'd0, 8'd0, 8'd0, 24'h000000, 24'h000000, 24'h000000);
    send_layer(8'd255, 8'd255, 8'd255, 24'h000000, 24'h000000, 24'h000000);
    send_layer(8'd255, 8'd0, 8'd128, 24'h7FFFFF, 24'h000000, 24'h000000);
    send_layer(8'd255, 8'd255, 8'd255, 24'h800000, 24'h800000, 24'h800000);
    send_layer(8'd1, 8'd2, 8'd3, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_layer(8'd255, 8'd10, 8'd0, 24'd256, 24'h000000, 24'hFFFFFF);

    quiesce();
    setup(4, 1'b1, 1'b1, 48'hFFFF_FFFF_FFFF, 48'h0, 48'hFFFF_0000_8000, 48'h0001_0200_0100);
    send_layer(8'd255, 8'd255, 8'd255, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_layer(8'd255, 8'd255, 8'd255, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_layer(8'd255, 8'd255, 8'd255, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_layer(8'd255, 8'd255, 8'd255, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_layer(8'd17, 8'd0, 8'd255, 24'h000100, 24'h800000, 24'h000000);
    send_layer(8'd255, 8'd128, 8'd1, 24'h800000, 24'h7FFFFF, 24'hFFFF00);
    send_layer(8'd0, 8'd255, 8'd200, 24'h000000, 24'h000000, 24'h000000);
    send_layer(8'd99, 8'd7, 8'd255, 24'hFFFFFF, 24'h000001, 24'h012345);

    // partial texel, then full bright clears it
    quiesce();
    setup(3, 1'b1, 1'b0, SCALE_RESET, SCALE_RESET, SCALE_RESET, SCALE_RESET);
    send_layer(8'd200, 8'd100, 8'd50, 24'h001000, 24'h000000, 24'hFFF000);
    quiesce();
    write_reg(CFG_HAS_SAMPLES, SCALE_W'(0));
    send_layer(8'd12, 8'd34, 8'd56, 24'h800000, 24'h7FFFFF, 24'h000000);
    send_layer(8'd255, 8'd0, 8'd255, 24'h000000, 24'h000000, 24'h000000);
    quiesce();
    write_reg(CFG_HAS_SAMPLES, SCALE_W'(1));
    write_reg(CFG_NUM_MAPS, SCALE_W'(0));
    send_layer(8'd40, 8'd80, 8'd120, 24'h000080, 24'h000080, 24'h000080);
    send_layer(8'd255, 8'd1, 8'd64, 24'h000000, 24'hFFFFFF, 24'h000000);
    quiesce();
    write_reg(CFG_NUM_MAPS, SCALE_W'(7));
    send_layer(8'd100, 8'd100, 8'd100, 24'h000000, 24'h000000, 24'h000000);
    send_layer(8'd100, 8'd100, 8'd100, 24'h000000, 24'h000000, 24'h000000);
    // layer count drops mid texel
    quiesce();
    write_reg(CFG_NUM_MAPS, SCALE_W'(2));
    send_layer(8'd100, 8'd100, 8'd100, 24'h000000, 24'h000000, 24'h000000);

    for (int p = 0; p < RAND_PHASES; p++) begin
      quiesce();
      nm = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
      setup(nm, $urandom_range(0, 7) != 0, 1'($urandom_range(0, 1)),
            pick_scale(), pick_scale(), pick_scale(), pick_scale());
      if (p == RAND_PHASES - 1) begin
        stall_odds = 0;
        send_odds  = 0;
      end else begin
        stall_odds = pick_odds();
        send_odds  = pick_odds();
      end
      pause_at = $urandom_range(5, PHASE_ITEMS - 5);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == pause_at) begin
          s_axis_tvalid <= 1'b0;
          @(negedge clk_i);
          while (due != 0) @(negedge clk_i);
        end
        send_random_layer();
      end
    end

    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (due != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    if (fails == 0)
      $display("lightmap_style_combine_pack_tb passed");
    else
      $display("lightmap_style_combine_pack_tb failed");
    $finish;
  end

endmodule
